>>> src/sha256_pkg.sv
// SHA-256 stream hasher: shared types, constants and round functions.
// Used by all modules of the hasher; depends on nothing.
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Front-to-back command: one packed word of 4 message bytes, or a control.
  typedef enum logic [1:0] {
    CMD_WORD  = 2'd0,   // 32-bit message word for the schedule
    CMD_FINAL = 2'd1    // end of message: emit digest and reinitialize
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_LOAD,     // collect 16 words
    BK_ROUND,    // 64 rounds
    BK_ADD,      // fold into chaining words
    BK_EMIT      // stream out digest
  } bk_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,     // taking bytes
    FR_PAD80,    // emit word holding 0x80
    FR_ZERO,     // emit zero words up to word 14
    FR_LEN_HI,
    FR_LEN_LO,
    FR_FINAL
  } fr_state_t;

  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [3:0] LenWordIdx = 4'd14;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

endpackage

>>> src/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: front end, command queue, compression core.
// Depends on sha256_pkg, sha256_front, sha256_queue, sha256_core.
//
//   side    | signals                 | carries
//   input   | push, full, in_item     | one byte and/or end of message
//   output  | empty, pop, out_item    | one digest word
//
// Byte items are taken one per cycle while full is low; every fourth byte moves a
// word into the queue. Each 64-byte block passes through the round and fold states
// of the core's single round unit, during which the queue soaks up only 16 bytes;
// the other 48 bytes then arrive one per cycle, so a long message runs below the byte rate.
// End of message adds up to two padded blocks; then 8 digest words stream out.
// rst is synchronous; full holds during padding and whenever the queue is full.
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  sha256_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output sha256_pkg::out_item_t out_item
);

  logic             in_take, f_busy, f_valid, q_can_wr, q_can_rd, q_rd;
  sha256_pkg::cmd_t f_cmd, q_cmd;
  logic             out_valid;

  // Front stalls whenever it might need to write a word the queue cannot take
  assign full    = f_busy || !q_can_wr;
  assign in_take = push && !full;
  assign empty   = !out_valid;

  sha256_front u_front (
    .clk(clk), .rst(rst), .in_item(in_item), .in_take(in_take), .busy(f_busy),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(q_can_wr)
  );

  sha256_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst), .wr(f_valid), .wr_data(f_cmd), .can_wr(q_can_wr),
    .rd(q_rd), .can_rd(q_can_rd), .rd_data(q_cmd)
  );

  sha256_core u_core (
    .clk(clk), .rst(rst), .cmd_valid(q_can_rd), .cmd(q_cmd), .cmd_take(q_rd),
    .out_valid(out_valid), .out_item(out_item), .out_take(pop && out_valid)
  );

endmodule

>>> src/sha256_front.sv
// SHA-256 front end: packs bytes into words, counts bits, generates padding.
// Depends on sha256_pkg.
module sha256_front (
  input  logic                 clk,
  input  logic                 rst,
  input  sha256_pkg::in_item_t in_item,
  input  logic                 in_take,
  output logic                 busy,
  output logic                 cmd_valid,
  output sha256_pkg::cmd_t     cmd,
  input  logic                 cmd_ready
);

  sha256_pkg::fr_state_t state, state_next;
  logic [63:0] total_bits;
  logic [5:0]  block_fill;     // bytes in current block
  logic [23:0] part;           // up to three pending bytes, big-endian
  logic [3:0]  pad_word;       // word position during padding

  logic        byte_in;
  logic [1:0]  lane;
  logic [5:0]  fill_inc;       // fill after the incoming byte, wraps at 64
  logic [31:0] full_word;
  logic [31:0] pad_first;

  assign byte_in   = in_take && in_item.byte_present;
  assign lane      = block_fill[1:0];
  assign fill_inc  = block_fill + 6'd1;
  assign full_word = {part, in_item.data_byte};

  // Word with 0x80 at the current lane and zeros after it
  always_comb begin
    unique case (lane)
      2'd0:    pad_first = {sha256_pkg::PadByte, 24'd0};
      2'd1:    pad_first = {part[7:0], sha256_pkg::PadByte, 16'd0};
      2'd2:    pad_first = {part[15:0], sha256_pkg::PadByte, 8'd0};
      default: pad_first = {part, sha256_pkg::PadByte};
    endcase
  end

  // Next state and command output
  always_comb begin
    state_next = state;
    cmd_valid  = 1'b0;
    cmd.kind   = sha256_pkg::CMD_WORD;
    cmd.word   = full_word;
    unique case (state)
      sha256_pkg::FR_IDLE: begin
        cmd_valid = byte_in && (lane == 2'd3);
        if (in_take && in_item.end_of_message) state_next = sha256_pkg::FR_PAD80;
      end
      sha256_pkg::FR_PAD80: begin
        cmd_valid = 1'b1;
        cmd.word  = pad_first;
        if (cmd_ready) state_next = sha256_pkg::FR_ZERO;
      end
      sha256_pkg::FR_ZERO: begin
        cmd.word = 32'd0;
        if (pad_word == sha256_pkg::LenWordIdx) begin
          state_next = sha256_pkg::FR_LEN_HI;
        end else begin
          cmd_valid = 1'b1;
        end
      end
      sha256_pkg::FR_LEN_HI: begin
        cmd_valid = 1'b1;
        cmd.word  = total_bits[63:32];
        if (cmd_ready) state_next = sha256_pkg::FR_LEN_LO;
      end
      sha256_pkg::FR_LEN_LO: begin
        cmd_valid = 1'b1;
        cmd.word  = total_bits[31:0];
        if (cmd_ready) state_next = sha256_pkg::FR_FINAL;
      end
      default: begin
        cmd_valid = 1'b1;
        cmd.kind  = sha256_pkg::CMD_FINAL;
        cmd.word  = 32'd0;
        if (cmd_ready) state_next = sha256_pkg::FR_IDLE;
      end
    endcase
  end

  assign busy = (state != sha256_pkg::FR_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Byte gathering and padding position
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits <= 64'd0;
      block_fill <= 6'd0;
      pad_word   <= 4'd0;
    end else begin
      unique case (state)
        sha256_pkg::FR_IDLE: begin
          if (byte_in) begin
            part       <= {part[15:0], in_item.data_byte};
            total_bits <= total_bits + 64'd8;
            block_fill <= fill_inc;
            // 0x80 lands in the word that holds the next free byte
            if (in_item.end_of_message) pad_word <= fill_inc[5:2];
            else pad_word <= block_fill[5:2];
          end else begin
            pad_word <= block_fill[5:2];
          end
        end
        sha256_pkg::FR_PAD80: if (cmd_ready) pad_word <= pad_word + 4'd1;
        sha256_pkg::FR_ZERO: if (cmd_ready && pad_word != sha256_pkg::LenWordIdx)
          pad_word <= pad_word + 4'd1;
        sha256_pkg::FR_FINAL: if (cmd_ready) begin
          total_bits <= 64'd0;
          block_fill <= 6'd0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/sha256_queue.sv
// Short command queue between front and back of the SHA-256 hasher.
// Depends on sha256_pkg.
module sha256_queue #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sha256_pkg::cmd_t wr_data,
  output logic             can_wr,
  input  logic             rd,
  output logic             can_rd,
  output sha256_pkg::cmd_t rd_data
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha256_pkg::cmd_t mem [Depth];
  logic [Aw-1:0] wp, rp;
  logic [Aw:0]   count;

  assign can_wr  = (count != Depth[Aw:0]);
  assign can_rd  = (count != '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && can_wr) mem[wp] <= wr_data;
  end

  // Pointers wrap at Depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr && can_wr) wp <= (wp == Aw'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd && can_rd) rp <= (rp == Aw'(Depth - 1)) ? '0 : rp + 1'b1;
      count <= count + Aw'((wr && can_wr) ? 1 : 0) - Aw'((rd && can_rd) ? 1 : 0);
    end
  end

endmodule

>>> src/sha256_core.sv
// SHA-256 back end: message schedule, one round per cycle, digest output register.
// Depends on sha256_pkg.
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  sha256_pkg::cmd_t      cmd,
  output logic                  cmd_take,
  output logic                  out_valid,
  output sha256_pkg::out_item_t out_item,
  input  logic                  out_take
);

  sha256_pkg::bk_state_t state, state_next;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [31:0] w [16];      // sliding schedule window, w[0] oldest
  logic [5:0]  cnt;
  logic [2:0]  oidx;
  logic        blk_done;    // round phase entered from a full block

  logic [31:0] t1, t2, w_new;

  assign t1 = v[7] + sha256_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha256_pkg::RoundK[cnt] + w[0];
  assign t2 = sha256_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  assign w_new = w[0] + sha256_pkg::sig0(w[1]) + w[9] + sha256_pkg::sig1(w[14]);

  // Control
  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    unique case (state)
      sha256_pkg::BK_LOAD: begin
        cmd_take = cmd_valid;
        if (cmd_valid && cmd.kind == sha256_pkg::CMD_FINAL) state_next = sha256_pkg::BK_EMIT;
        else if (cmd_valid && cnt == 6'd15) state_next = sha256_pkg::BK_ROUND;
      end
      sha256_pkg::BK_ROUND: if (cnt == 6'd63) state_next = sha256_pkg::BK_ADD;
      sha256_pkg::BK_ADD: state_next = sha256_pkg::BK_LOAD;
      default: if (out_take && oidx == 3'd7) state_next = sha256_pkg::BK_LOAD;
    endcase
  end

  assign out_valid            = (state == sha256_pkg::BK_EMIT);
  assign out_item.digest_word = h[oidx];
  assign out_item.word_index  = oidx;
  assign out_item.last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) state <= sha256_pkg::BK_LOAD;
    else state <= state_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= 6'd0;
      oidx     <= 3'd0;
      blk_done <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
    end else begin
      unique case (state)
        sha256_pkg::BK_LOAD: begin
          if (cmd_valid && cmd.kind == sha256_pkg::CMD_WORD) begin
            for (int i = 0; i < 15; i++) w[i] <= w[i+1];
            w[15] <= cmd.word;
            cnt   <= (cnt == 6'd15) ? 6'd0 : cnt + 6'd1;
            if (cnt == 6'd15) begin
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              blk_done <= 1'b1;
            end
          end
          oidx <= 3'd0;
        end
        sha256_pkg::BK_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          cnt  <= cnt + 6'd1;
        end
        sha256_pkg::BK_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          blk_done <= 1'b0;
        end
        default: begin
          if (out_take) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7)
              for (int i = 0; i < 8; i++) h[i] <= sha256_pkg::InitH[i];
          end
        end
      endcase
    end
  end

  // Checks
  a_cnt_load: assert property (@(posedge clk) disable iff (rst)
    state == sha256_pkg::BK_LOAD |-> cnt < 6'd16) else $error("load count overflow");
  a_round_enter: assert property (@(posedge clk) disable iff (rst)
    $rose(state == sha256_pkg::BK_ROUND) |-> cnt == 6'd0 && blk_done)
    else $error("rounds began mid-block");
  a_emit_oidx: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> oidx == 3'd0 && cnt == 6'd0) else $error("digest start misaligned");

endmodule

>>> sim/sha256_stream_hasher_tb.sv
// Testbench for sha256_stream_hasher: byte items in, digest words out, checked
// against a SHA-256 predictor kept in this file. Depends on sha256_pkg and the RTL.
module sha256_stream_hasher_tb;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  sha256_pkg::in_item_t  in_item;
  logic                  empty;
  logic                  pop;
  sha256_pkg::out_item_t out_item;

  sha256_stream_hasher i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  // Predictor state
  logic [31:0] hash_h [8];
  logic [63:0] msg_bits;
  logic [7:0]  blk [64];
  int          fill;

  sha256_pkg::in_item_t  pending_items[$];
  sha256_pkg::out_item_t digest_words[$];
  int          errors;
  longint      cycles;
  bit          tail_phase;   // no idling near the end
  int          rx_hold;      // long receiver hold-off, counted in cycles
  bit          drain_wait;   // sender pauses until all digests come back
  int          tx_gap;
  int          rx_gap;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression over blk into hash_h
  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::RoundK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::InitH[i];
    msg_bits = '0;
    fill = 0;
  endtask

  // Advance the predictor by one accepted item
  task automatic hash_absorb(sha256_pkg::in_item_t it);
    sha256_pkg::out_item_t o;
    if (it.byte_present) begin
      blk[fill] = it.data_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        sha_compress();
        fill = 0;
      end
    end
    if (it.end_of_message) begin
      blk[fill] = sha256_pkg::PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        sha_compress();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63-i] = msg_bits[8*i +: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        o.digest_word = hash_h[i];
        o.word_index  = 3'(i);
        o.last_word   = (i == 7);
        digest_words.push_back(o);
      end
      hash_restart();
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic add_item(bit pres, logic [7:0] b, bit eom);
    sha256_pkg::in_item_t it;
    it.data_byte = b;
    it.byte_present = pres;
    it.end_of_message = eom;
    pending_items.push_back(it);
  endtask

  task automatic add_message(int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_item(0, 8'($urandom), 0);
      add_item(1, 8'($urandom), (i == len - 1) && $urandom_range(0, 1));
    end
    if (pending_items[$].end_of_message == 0) add_item(0, 8'($urandom), 1);
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 0;
      in_item <= '0;
      tx_gap <= 0;
    end else begin
      if (push && !full) begin
        hash_absorb(in_item);
        void'(pending_items.pop_front());
      end
      if (push && full) begin
        // keep offering
      end else if (tx_gap > 0) begin
        push <= 0;
        tx_gap <= tx_gap - 1;
      end else if (drain_wait && digest_words.size() != 0) begin
        push <= 0;
      end else if (pending_items.size() != 0 && !(push && !full && pending_items.size() == 0))
      begin
        if (!tail_phase && $urandom_range(0, 19) == 0) begin
          push <= 0;
          tx_gap <= $urandom_range(1, 15) - 1;
        end else begin
          push <= 1;
          in_item <= pending_items[0];
        end
      end else begin
        push <= 0;
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk) begin
    sha256_pkg::out_item_t want;
    if (rst) begin
      pop <= 0;
      rx_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (digest_words.size() == 0) begin
          report_mismatch("unexpected digest word", out_item.digest_word, 0);
        end else begin
          want = digest_words.pop_front();
          if (out_item.digest_word !== want.digest_word)
            report_mismatch("digest_word", out_item.digest_word, want.digest_word);
          if (out_item.word_index !== want.word_index)
            report_mismatch("word_index", out_item.word_index, want.word_index);
          if (out_item.last_word !== want.last_word)
            report_mismatch("last_word", out_item.last_word, want.last_word);
        end
      end
      if (rx_hold > 0) begin
        pop <= 0;
        rx_hold <= rx_hold - 1;
      end else if (rx_gap > 0) begin
        pop <= 0;
        rx_gap <= rx_gap - 1;
      end else if (!tail_phase && $urandom_range(0, 19) == 0) begin
        pop <= 0;
        rx_gap <= $urandom_range(1, 15) - 1;
      end else begin
        pop <= 1;
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    tail_phase = 0;
    rx_hold = 0;
    drain_wait = 0;
    push = 0;
    pop = 0;
    in_item = '0;
    hash_restart();
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: empty message, idle items, field extremes, two-block padding,
    // and a message that fills a whole block from data
    add_item(0, 8'hff, 0);
    add_item(0, 8'h00, 1);
    add_item(1, 8'h00, 0);
    add_item(1, 8'hff, 1);
    add_item(1, 8'h61, 0);
    add_item(1, 8'h62, 0);
    add_item(1, 8'h63, 0);
    add_item(0, 8'h00, 1);
    add_message(56);
    add_message(70);

    // Receiver holds off for a long stretch while the sender keeps going
    rx_hold = 400;
    for (int m = 0; m < 4; m++) add_message($urandom_range(0, 8));
    wait (pending_items.size() == 0);

    // Sender waits until every digest has returned
    drain_wait = 1;
    add_message(3);
    wait (pending_items.size() == 0 && digest_words.size() == 0);
    drain_wait = 0;

    // Random short messages, then loose items closed by an end of message
    for (int m = 0; m < 4; m++) add_message($urandom_range(0, 12));
    for (int k = 0; k < 10; k++) add_item($urandom_range(0, 1), 8'($urandom), 0);
    add_item(0, 8'h00, 1);
    wait (pending_items.size() < 20);
    tail_phase = 1;
    wait (pending_items.size() == 0 && digest_words.size() == 0);
    repeat (300) @(posedge clk);

    if (errors == 0 && digest_words.size() == 0) begin
      $display("sha256_stream_hasher: match");
    end else begin
      $display("sha256_stream_hasher: mismatch");
    end
    $finish;
  end

endmodule
